/* sv/ceca_pkg.sv */
// Shared types and constants for the contrast-enforcing colour adjust block.
// Holds the sRGB linearisation table builder, luminance weights and the
// request type of the shared multiplier. No dependencies.
`default_nettype none

package ceca_pkg;

  localparam int CH_W     = 8;
  localparam int LIN_W    = 17;
  localparam int WEIGHT_W = 16;
  localparam int LUM_W    = 33;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 19;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int CMP_W    = 46;
  localparam int BLEND_W  = 17;

  localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
  localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

  localparam logic [LUM_W-1:0] LUM_OFFSET = 33'd214748365;
  localparam logic [LUM_W-1:0] LUM_HALF   = 33'h0_8000_0000;

  // floor(x / 510) as (x * RECIP_510) >> RECIP_SHIFT, exact for x < 2^17
  localparam logic [MUL_B_W-1:0] RECIP_510 = 19'd263173;
  localparam int RECIP_SHIFT = 27;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int RATIO_W     = 13;
  localparam logic REG_MIN_RATIO = 1'b0;
  localparam logic [RATIO_W-1:0] MIN_RATIO_RESET = 13'd1152;

  typedef logic [LIN_W-1:0] lin_rom_t [256];

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = (r * r) >> 30;
    r4 = (r2 * r2) >> 30;
    return (r4 * r) >> 30;
  endfunction

  // Linear-light value of an 8-bit sRGB code, Q1.16 rounded half up
  function automatic logic [LIN_W-1:0] lin_value(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] l30;
    if (v <= 64'd10) begin
      return LIN_W'((64'd2 * v * 64'd1310720 + 64'd65892) / 64'd131784);
    end
    x  = ((64'd1000 * v + 64'd14025) << 30) / 64'd269025;
    s  = (x * x) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (pow5_q30(mid) <= s) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    l30 = (s * lo) >> 30;
    return LIN_W'((l30 + (64'd1 << 13)) >> 14);
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = lin_value(64'(i));
    end
    return t;
  endfunction

endpackage

`default_nettype wire

/* sv/ceca_in_if.sv */
// Input channel: one foreground/background colour pair per transfer.
// Depends on nothing.
`default_nettype none

interface ceca_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] fg_red;
  logic [7:0] fg_green;
  logic [7:0] fg_blue;
  logic       fg_has_rgb;
  logic [7:0] bg_red;
  logic [7:0] bg_green;
  logic [7:0] bg_blue;
  logic       bg_has_rgb;

  modport source (
    output valid, fg_red, fg_green, fg_blue, fg_has_rgb,
           bg_red, bg_green, bg_blue, bg_has_rgb,
    input  ready
  );

  modport sink (
    input  valid, fg_red, fg_green, fg_blue, fg_has_rgb,
           bg_red, bg_green, bg_blue, bg_has_rgb,
    output ready
  );
endinterface

`default_nettype wire

/* sv/ceca_out_if.sv */
// Output channel: one adjusted colour per transfer.
// Depends on nothing.
`default_nettype none

interface ceca_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       adjusted;

  modport source (
    output valid, out_red, out_green, out_blue, adjusted,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, adjusted,
    output ready
  );
endinterface

`default_nettype wire

/* sv/ceca_mul.sv */
// Shared unsigned multiplier with a registered product.
// Depends on ceca_pkg.
`default_nettype none

module ceca_mul (
  input  wire logic                       clk,
  input  wire ceca_pkg::mul_req_t         req,
  output logic [ceca_pkg::PROD_W-1:0]     prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= ceca_pkg::PROD_W'(req.a) * ceca_pkg::PROD_W'(req.b);
    end
  end

endmodule

`default_nettype wire

/* sv/contrast_enforcing_colour_adjust.sv */
// Top level of the contrast-enforcing colour adjust block: sequencer,
// registers and APB configuration. Depends on ceca_pkg, ceca_in_if,
// ceca_out_if and ceca_mul.
//
//  channel   | kind            | carries
//  colours   | valid/ready in  | fg and bg RGB with has_rgb flags
//  result    | valid/ready out | out RGB and adjusted flag
//  apb       | APB write/read  | min_contrast_ratio at byte 0
//
// One item at a time; every product goes through the single shared multiplier.
// Either flag clear: the pair goes straight to done. Otherwise up to MAX_STEPS
// blend steps are tried (none when the ratio already holds).
// Output register lets a new pair be taken while a result waits.
// rst is synchronous, active high; min_contrast_ratio resets to 4.5.
`default_nettype none

module contrast_enforcing_colour_adjust #(
  parameter int MAX_STEPS = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  ceca_in_if.sink                                  colours,
  ceca_out_if.source                               result,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ceca_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [ceca_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [ceca_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int REM_W  = STEP_W + 1;
  localparam logic [STEP_W-1:0] STEPS = STEP_W'(MAX_STEPS);
  localparam logic [7:0]        Q0    = 8'(255 / MAX_STEPS);
  localparam logic [REM_W-1:0]  R0    = REM_W'(255 % MAX_STEPS);
  localparam logic [REM_W-1:0]  STEPS_X = REM_W'(MAX_STEPS);

  localparam ceca_pkg::lin_rom_t LIN_ROM = ceca_pkg::build_lin_rom();

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_LUM      = 7'b0000010,
    ST_CMP_PREP = 7'b0000100,
    ST_CMP_MUL  = 7'b0001000,
    ST_CMP_TEST = 7'b0010000,
    ST_BLEND    = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_t;

  state_t state;
  logic [3:0] cnt;
  logic       pass;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] rem;
  logic [7:0] alpha;
  logic       tgt_black;
  logic       adj;
  logic [7:0] fg   [3];
  logic [7:0] bg   [3];
  logic [7:0] cand [3];
  logic [ceca_pkg::LUM_W-1:0] acc;
  logic [ceca_pkg::LUM_W-1:0] lbg;
  logic [ceca_pkg::LUM_W-1:0] lcur;
  logic [ceca_pkg::LUM_W-1:0] hi_k;
  logic [ceca_pkg::LUM_W-1:0] lo_k;
  logic [ceca_pkg::BLEND_W-1:0] x;
  logic [ceca_pkg::RATIO_W-1:0] min_ratio;

  logic       res_valid;
  logic [7:0] res_red;
  logic [7:0] res_green;
  logic [7:0] res_blue;
  logic       res_adjusted;

  ceca_pkg::mul_req_t              mreq;
  logic [ceca_pkg::PROD_W-1:0]     prod;

  logic [1:0] ch_sel;
  logic [7:0] fg_ch;
  logic [7:0] bg_ch;
  logic [7:0] cand_ch;
  logic [7:0] lum_v;
  logic [ceca_pkg::WEIGHT_W-1:0] weight;
  logic [ceca_pkg::LUM_W-1:0]    lum_sum;
  logic [ceca_pkg::BLEND_W-1:0]  white_term;
  logic [ceca_pkg::BLEND_W-1:0]  num;
  logic                          met;
  logic [REM_W-1:0]              rem_sum;
  logic                          rem_carry;
  logic                          cfg_wr;
  logic                          cfg_hit;
  logic                          load_out;

  ceca_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  // ---------------- APB ----------------
  assign cfg_hit = (paddr[2] == ceca_pkg::REG_MIN_RATIO);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? ceca_pkg::CFG_DATA_W'(min_ratio) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_ratio <= ceca_pkg::MIN_RATIO_RESET;
    end else if (cfg_wr) begin
      min_ratio <= pwdata[ceca_pkg::RATIO_W-1:0];
    end
  end

  // ---------------- datapath selection ----------------
  assign ch_sel = (state == ST_BLEND) ? cnt[3:2] : cnt[1:0];

  always_comb begin
    unique case (ch_sel)
      2'd0: begin
        fg_ch = fg[0]; bg_ch = bg[0]; cand_ch = cand[0]; weight = ceca_pkg::W_RED;
      end
      2'd1: begin
        fg_ch = fg[1]; bg_ch = bg[1]; cand_ch = cand[1]; weight = ceca_pkg::W_GREEN;
      end
      2'd2: begin
        fg_ch = fg[2]; bg_ch = bg[2]; cand_ch = cand[2]; weight = ceca_pkg::W_BLUE;
      end
      default: begin
        fg_ch = '0; bg_ch = '0; cand_ch = '0; weight = '0;
      end
    endcase
  end

  assign lum_v      = pass ? cand_ch : bg_ch;
  assign lum_sum    = acc + prod[ceca_pkg::LUM_W-1:0];
  assign white_term = ceca_pkg::BLEND_W'({alpha, 8'd0}) - ceca_pkg::BLEND_W'(alpha);
  assign num        = ceca_pkg::BLEND_W'(prod[15:0]) + (tgt_black ? '0 : white_term);
  assign met        = ceca_pkg::CMP_W'({hi_k, 8'd0}) >= prod[ceca_pkg::CMP_W-1:0];
  assign rem_sum    = REM_W'(rem) + R0;
  assign rem_carry  = (rem_sum >= STEPS_X);
  assign load_out   = (state == ST_DONE) && (!res_valid || result.ready);

  always_comb begin
    mreq = '0;
    unique case (state)
      ST_LUM: begin
        mreq.en = (cnt != 4'd3);
        mreq.a  = ceca_pkg::MUL_A_W'(weight);
        mreq.b  = ceca_pkg::MUL_B_W'(LIN_ROM[lum_v]);
      end
      ST_CMP_MUL: begin
        mreq.en = 1'b1;
        mreq.a  = lo_k;
        mreq.b  = ceca_pkg::MUL_B_W'(min_ratio);
      end
      ST_BLEND: begin
        mreq.en = !cnt[0];
        if (!cnt[1]) begin
          mreq.a = ceca_pkg::MUL_A_W'(fg_ch);
          mreq.b = ceca_pkg::MUL_B_W'(8'd255 - alpha);
        end else begin
          mreq.a = ceca_pkg::MUL_A_W'(x);
          mreq.b = ceca_pkg::RECIP_510;
        end
      end
      default: mreq = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      pass  <= 1'b0;
      step  <= '0;
      rem   <= '0;
      alpha <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (colours.valid) begin
            cnt   <= '0;
            pass  <= 1'b0;
            step  <= '0;
            rem   <= '0;
            alpha <= '0;
            if (colours.fg_has_rgb && colours.bg_has_rgb) begin
              state <= ST_LUM;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_LUM: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd3) begin
            cnt <= '0;
            if (!pass) begin
              pass <= 1'b1;
            end else begin
              state <= ST_CMP_PREP;
            end
          end
        end
        ST_CMP_PREP: state <= ST_CMP_MUL;
        ST_CMP_MUL:  state <= ST_CMP_TEST;
        ST_CMP_TEST: begin
          if (met || step == STEPS) begin
            state <= ST_DONE;
          end else begin
            step  <= step + STEP_W'(1);
            rem   <= rem_carry ? STEP_W'(rem_sum - STEPS_X) : STEP_W'(rem_sum);
            alpha <= alpha + Q0 + 8'(rem_carry);
            cnt   <= '0;
            state <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd11) begin
            cnt   <= '0;
            state <= ST_LUM;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        fg[0]   <= colours.fg_red;
        fg[1]   <= colours.fg_green;
        fg[2]   <= colours.fg_blue;
        bg[0]   <= colours.bg_red;
        bg[1]   <= colours.bg_green;
        bg[2]   <= colours.bg_blue;
        cand[0] <= colours.fg_red;
        cand[1] <= colours.fg_green;
        cand[2] <= colours.fg_blue;
        adj     <= 1'b0;
      end
      ST_LUM: begin
        if (cnt == 4'd0) begin
          acc <= '0;
        end else begin
          acc <= lum_sum;
        end
        if (cnt == 4'd3) begin
          if (!pass) begin
            lbg       <= lum_sum;
            tgt_black <= (lum_sum > ceca_pkg::LUM_HALF);
          end else begin
            lcur <= lum_sum;
          end
        end
      end
      ST_CMP_PREP: begin
        if (lcur > lbg) begin
          hi_k <= lcur + ceca_pkg::LUM_OFFSET;
          lo_k <= lbg + ceca_pkg::LUM_OFFSET;
        end else begin
          hi_k <= lbg + ceca_pkg::LUM_OFFSET;
          lo_k <= lcur + ceca_pkg::LUM_OFFSET;
        end
      end
      ST_CMP_TEST: begin
        adj <= (step != '0);
      end
      ST_BLEND: begin
        if (cnt[1:0] == 2'd1) begin
          x <= ceca_pkg::BLEND_W'({num, 1'b0} + 18'd255);
        end
        if (cnt[1:0] == 2'd3) begin
          cand[ch_sel] <= prod[ceca_pkg::RECIP_SHIFT +: 8];
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_red      <= cand[0];
      res_green    <= cand[1];
      res_blue     <= cand[2];
      res_adjusted <= adj;
    end
  end

  assign colours.ready    = (state == ST_IDLE);
  assign result.valid     = res_valid;
  assign result.out_red   = res_red;
  assign result.out_green = res_green;
  assign result.out_blue  = res_blue;
  assign result.adjusted  = res_adjusted;

  // ---------------- assertions ----------------
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEPS)
    else $error("blend step beyond limit");

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP_TEST) && (step == STEPS) |=> state == ST_DONE)
    else $error("last blend step did not finish the item");

  a_full_target: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLEND) && (step == STEPS) |-> alpha == 8'hFF)
    else $error("final blend alpha is not full target");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && res_valid && !result.ready |=> state == ST_DONE)
    else $error("finished item dropped while output stalled");

endmodule

`default_nettype wire

/* bench/contrast_enforcing_colour_adjust_tb.sv */
// Self-checking bench for contrast_enforcing_colour_adjust: directed and random colour pairs
// against a bit-exact WCAG contrast predictor, over several min_contrast_ratio settings.
// Depends on ceca_pkg, ceca_in_if, ceca_out_if and the block itself.
`timescale 1ns / 100ps

module contrast_enforcing_colour_adjust_tb;

  localparam int BLEND_STEPS    = 20;
  localparam int PHASE_ITEMS    = 175;
  localparam int MAX_IDLE       = 17;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 400;
  localparam logic [ceca_pkg::CFG_ADDR_W-1:0] RATIO_ADDR =
    ceca_pkg::CFG_ADDR_W'(4 * ceca_pkg::REG_MIN_RATIO);

  typedef struct packed {
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic       fg_has_rgb;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    logic       bg_has_rgb;
  } colour_pair_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       adjusted;
  } shade_t;

  class contrast_scoreboard;
    logic [ceca_pkg::LIN_W-1:0] lin_q16 [256];
    logic [ceca_pkg::RATIO_W-1:0] min_ratio;
    shade_t awaited_shades [$];
    int noted;
    int checked;
    int blended;
    int mismatches;

    function new();
      for (int i = 0; i < 256; i++) begin
        lin_q16[i] = linearise(i);
      end
      min_ratio  = ceca_pkg::MIN_RATIO_RESET;
      noted      = 0;
      checked    = 0;
      blended    = 0;
      mismatches = 0;
    endfunction

    // sRGB code to linear light, Q1.16; gamma part via Q30 fifth root of x^2
    function logic [ceca_pkg::LIN_W-1:0] linearise(int unsigned v);
      logic [63:0] xq;
      logic [63:0] sq;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] m2;
      logic [63:0] m4;
      logic [63:0] l30;
      if (v <= 10) begin
        return ceca_pkg::LIN_W'((64'(v) * 2621440 + 65892) / 131784);
      end
      xq = ((64'(v) * 1000 + 14025) << 30) / 269025;
      sq = (xq * xq) >> 30;
      lo = 64'd0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        m2  = (mid * mid) >> 30;
        m4  = (m2 * m2) >> 30;
        if (((m4 * mid) >> 30) <= sq) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      l30 = (sq * lo) >> 30;
      return ceca_pkg::LIN_W'((l30 + 64'd8192) >> 14);
    endfunction

    function logic [63:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return 64'(ceca_pkg::W_RED) * 64'(lin_q16[r]) +
             64'(ceca_pkg::W_GREEN) * 64'(lin_q16[g]) +
             64'(ceca_pkg::W_BLUE) * 64'(lin_q16[b]);
    endfunction

    function bit contrast_ok(logic [63:0] la, logic [63:0] lb);
      logic [63:0] hi_l;
      logic [63:0] lo_l;
      hi_l = (la > lb) ? la : lb;
      lo_l = (la > lb) ? lb : la;
      return (hi_l + 64'(ceca_pkg::LUM_OFFSET)) * 256 >=
             64'(min_ratio) * (lo_l + 64'(ceca_pkg::LUM_OFFSET));
    endfunction

    function logic [7:0] mix(logic [7:0] f, logic [7:0] t, logic [63:0] a);
      return 8'(((64'(f) * (255 - a) + 64'(t) * a) * 2 + 255) / 510);
    endfunction

    function shade_t enforce_contrast(colour_pair_t p);
      shade_t s;
      logic [63:0] bg_l;
      logic [63:0] alpha;
      logic [7:0] tgt;
      s.red      = p.fg_red;
      s.green    = p.fg_green;
      s.blue     = p.fg_blue;
      s.adjusted = 1'b0;
      if (!p.fg_has_rgb || !p.bg_has_rgb) begin
        return s;
      end
      bg_l = luma(p.bg_red, p.bg_green, p.bg_blue);
      if (contrast_ok(luma(p.fg_red, p.fg_green, p.fg_blue), bg_l)) begin
        return s;
      end
      // light background pulls toward black, dark toward white
      tgt = (bg_l > 64'(ceca_pkg::LUM_HALF)) ? 8'd0 : 8'd255;
      s.adjusted = 1'b1;
      for (int k = 1; k <= BLEND_STEPS; k++) begin
        alpha = 64'((k * 255) / BLEND_STEPS);
        if (alpha > 255) begin
          alpha = 255;
        end
        s.red   = mix(p.fg_red, tgt, alpha);
        s.green = mix(p.fg_green, tgt, alpha);
        s.blue  = mix(p.fg_blue, tgt, alpha);
        if (contrast_ok(luma(s.red, s.green, s.blue), bg_l)) begin
          break;
        end
      end
      return s;
    endfunction

    function void note_fault(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s", $time, msg);
      end
    endfunction

    function void note_pair(colour_pair_t p);
      noted++;
      awaited_shades.insert(awaited_shades.size(), enforce_contrast(p));
    endfunction

    function void check_shade(shade_t got);
      shade_t want;
      if (awaited_shades.size() == 0) begin
        note_fault($sformatf("unexpected result r=%0d g=%0d b=%0d adj=%0b",
                             got.red, got.green, got.blue, got.adjusted));
        return;
      end
      want = awaited_shades.pop_front();
      checked++;
      if (want.adjusted) begin
        blended++;
      end
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.adjusted !== want.adjusted) begin
        note_fault($sformatf(
          "result %0d: expected r=%0d g=%0d b=%0d adj=%0b, got r=%0d g=%0d b=%0d adj=%0b",
          checked, want.red, want.green, want.blue, want.adjusted,
          got.red, got.green, got.blue, got.adjusted));
      end
    endfunction

    function int pending();
      return awaited_shades.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ceca_pkg::CFG_ADDR_W-1:0] paddr;
  logic [ceca_pkg::CFG_DATA_W-1:0] pwdata;
  logic [ceca_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  ceca_in_if  colours_if ();
  ceca_out_if result_if ();

  contrast_enforcing_colour_adjust #(
    .MAX_STEPS(BLEND_STEPS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .colours (colours_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  contrast_scoreboard sb = new();
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int ratio_settings = 1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic colour_pair_t pair(int fr, int fg, int fb, bit fok,
                                        int br, int bg, int bb, bit bok);
    colour_pair_t p;
    p.fg_red     = 8'(fr);
    p.fg_green   = 8'(fg);
    p.fg_blue    = 8'(fb);
    p.fg_has_rgb = fok;
    p.bg_red     = 8'(br);
    p.bg_green   = 8'(bg);
    p.bg_blue    = 8'(bb);
    p.bg_has_rgb = bok;
    return p;
  endfunction

  function automatic logic [7:0] corner_code();
    logic [7:0] codes [8] = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd127, 8'd128, 8'd254, 8'd255};
    return codes[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c);
    int cv;
    int d;
    cv = c;
    d  = $urandom_range(0, 48);
    cv = cv + d - 24;
    if (cv < 0) begin
      cv = 0;
    end else if (cv > 255) begin
      cv = 255;
    end
    return 8'(cv);
  endfunction

  // mostly flagged pairs, many close in colour so the blend loop runs deep
  function automatic colour_pair_t random_pair();
    colour_pair_t p;
    int kind;
    logic [7:0] g;
    kind = $urandom_range(0, 99);
    p.bg_red   = 8'($urandom);
    p.bg_green = 8'($urandom);
    p.bg_blue  = 8'($urandom);
    p.fg_red   = 8'($urandom);
    p.fg_green = 8'($urandom);
    p.fg_blue  = 8'($urandom);
    if (kind >= 40 && kind < 70) begin
      p.fg_red   = nudge(p.bg_red);
      p.fg_green = nudge(p.bg_green);
      p.fg_blue  = nudge(p.bg_blue);
    end else if (kind >= 70 && kind < 85) begin
      g = 8'($urandom);
      p.fg_red   = g;
      p.fg_green = g;
      p.fg_blue  = g;
      g = 8'($urandom);
      p.bg_red   = g;
      p.bg_green = g;
      p.bg_blue  = g;
    end else if (kind >= 85) begin
      p.fg_red   = corner_code();
      p.fg_green = corner_code();
      p.fg_blue  = corner_code();
      p.bg_red   = corner_code();
      p.bg_green = corner_code();
      p.bg_blue  = corner_code();
    end
    p.fg_has_rgb = ($urandom_range(0, 9) != 0);
    p.bg_has_rgb = ($urandom_range(0, 9) != 0);
    return p;
  endfunction

  task automatic send_pair(colour_pair_t p);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      colours_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    colours_if.valid      <= 1'b1;
    colours_if.fg_red     <= p.fg_red;
    colours_if.fg_green   <= p.fg_green;
    colours_if.fg_blue    <= p.fg_blue;
    colours_if.fg_has_rgb <= p.fg_has_rgb;
    colours_if.bg_red     <= p.bg_red;
    colours_if.bg_green   <= p.bg_green;
    colours_if.bg_blue    <= p.bg_blue;
    colours_if.bg_has_rgb <= p.bg_has_rgb;
    do @(posedge clk); while (!colours_if.ready);
    sb.note_pair(p);
    if ($urandom_range(0, 29) == 0) begin
      tx_steady = !tx_steady;
    end
  endtask

  task automatic run_phase(int n);
    repeat (n) send_pair(random_pair());
    colours_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_min_ratio(logic [ceca_pkg::RATIO_W-1:0] r);
    logic [ceca_pkg::CFG_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RATIO_ADDR;
    pwdata  <= ceca_pkg::CFG_DATA_W'(r);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.min_ratio = r;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    ratio_settings++;
    if (rd !== ceca_pkg::CFG_DATA_W'(r)) begin
      sb.note_fault($sformatf("min_contrast_ratio readback: expected %0d, got %0d", r, rd));
    end
  endtask

  // result side: random stalls, checked on every transfer
  initial begin
    int stall;
    shade_t got;
    result_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      got.red      = result_if.out_red;
      got.green    = result_if.out_green;
      got.blue     = result_if.out_blue;
      got.adjusted = result_if.adjusted;
      sb.check_shade(got);
      if ($urandom_range(0, 29) == 0) begin
        rx_steady = !rx_steady;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (colours_if.valid && colours_if.ready) ||
          (result_if.valid && result_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [ceca_pkg::RATIO_W-1:0] ratio_plan [7];
    rst                   <= 1'b1;
    colours_if.valid      <= 1'b0;
    colours_if.fg_red     <= '0;
    colours_if.fg_green   <= '0;
    colours_if.fg_blue    <= '0;
    colours_if.fg_has_rgb <= 1'b0;
    colours_if.bg_red     <= '0;
    colours_if.bg_green   <= '0;
    colours_if.bg_blue    <= '0;
    colours_if.bg_has_rgb <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    ratio_plan[0] = 13'd256;
    ratio_plan[1] = 13'd5376;
    ratio_plan[2] = 13'd0;
    ratio_plan[3] = 13'd8191;
    ratio_plan[4] = 13'($urandom_range(256, 5376));
    ratio_plan[5] = 13'($urandom_range(256, 5376));
    ratio_plan[6] = ceca_pkg::MIN_RATIO_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs at the reset ratio of 4.5
    send_pair(pair(255, 255, 255, 0, 255, 255, 255, 1));   // fg flag clear
    send_pair(pair(0, 0, 0, 1, 0, 0, 0, 0));               // bg flag clear
    send_pair(pair(128, 128, 128, 0, 128, 128, 128, 0));
    send_pair(pair(0, 0, 0, 1, 255, 255, 255, 1));         // already meets ratio
    send_pair(pair(255, 255, 255, 1, 0, 0, 0, 1));
    send_pair(pair(128, 128, 128, 1, 128, 128, 128, 1));   // equal luminance
    send_pair(pair(255, 255, 255, 1, 255, 255, 255, 1));   // light bg, toward black
    send_pair(pair(0, 0, 0, 1, 0, 0, 0, 1));               // dark bg, toward white
    send_pair(pair(10, 5, 0, 1, 0, 0, 0, 1));              // linear segment of the curve
    send_pair(pair(11, 11, 11, 1, 12, 12, 12, 1));
    send_pair(pair(255, 0, 255, 1, 0, 255, 0, 1));
    send_pair(pair(255, 0, 0, 1, 255, 0, 0, 1));
    send_pair(pair(0, 255, 0, 1, 0, 255, 0, 1));
    send_pair(pair(0, 0, 255, 1, 0, 0, 255, 1));
    send_pair(pair(1, 2, 3, 1, 254, 253, 252, 1));
    send_pair(pair(118, 118, 118, 1, 188, 188, 188, 1));
    send_pair(pair(60, 60, 60, 1, 30, 30, 30, 1));
    send_pair(pair(200, 180, 160, 1, 255, 250, 240, 1));
    send_pair(pair(127, 127, 127, 1, 119, 119, 119, 1));
    send_pair(pair(85, 170, 254, 1, 1, 127, 128, 1));
    send_pair(pair(255, 255, 255, 1, 0, 0, 0, 0));
    run_phase(PHASE_ITEMS);

    foreach (ratio_plan[i]) begin
      set_min_ratio(ratio_plan[i]);
      run_phase(PHASE_ITEMS);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d colour pairs over %0d ratio settings, %0d results checked",
             sb.noted, ratio_settings, sb.checked);
    $display("%0d results blended, %0d mismatches, %0d still outstanding",
             sb.blended, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
